/* design/pud_pkg.sv */
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types, codes and helper functions for the percent-escape UTF-8 to
// UTF-16 path decoder.
// ----------------------------------------------------------------------------
package pud_pkg;

    localparam int UNIT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CP_W     = 21;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_UNIT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    localparam logic [UNIT_W-1:0] PERCENT_CHAR = 16'h0025;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h010000;
    localparam logic [CP_W-1:0]   CP_MAX       = 21'h10FFFF;

    // Escape parser state.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HI   = 3'b010,
        PH_LO   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    // Up to two results produced by one input transaction.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } emit_t;

    // Value of a hex digit in bits 3:0; bit 4 set when the unit is no digit.
    function automatic logic [4:0] hex_value(input logic [UNIT_W-1:0] u);
        logic [4:0] v;
        v = 5'd16;
        if (u >= 16'h0030 && u <= 16'h0039) begin
            v = {1'b0, 4'(u - 16'h0030)};
        end else if (u >= 16'h0061 && u <= 16'h0066) begin
            v = {1'b0, 4'(u - 16'h0061 + 16'd10)};
        end else if (u >= 16'h0041 && u <= 16'h0046) begin
            v = {1'b0, 4'(u - 16'h0041 + 16'd10)};
        end
        return v;
    endfunction

endpackage

/* design/pud_step.sv */
// ----------------------------------------------------------------------------
// pud_step
// Decoder state and the single-pass decode of one registered input unit.
// ----------------------------------------------------------------------------
module pud_step
    import pud_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [UNIT_W-1:0] unit,
    input  logic              end_of_string,
    output emit_t             emit
);

    phase_t          phase_reg, phase_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [1:0]      left_reg, left_next;
    logic            failed_reg, failed_next;
    logic            seen_reg, seen_next;

    logic [4:0]      hv;
    logic [7:0]      byte_val;
    logic [CP_W-1:0] cp_cont;
    logic [1:0]      left_dec;
    logic [CP_W-1:0] cp_emit;
    logic            do_emit;
    logic [CP_W-1:0] cp_off;

    always_comb begin
        hv       = hex_value(unit);
        byte_val = {nibble_reg, hv[3:0]};
        cp_cont  = {cp_reg[CP_W-7:0], byte_val[5:0]};
        left_dec = left_reg - 2'd1;
        cp_off   = cp_emit - SUPP_BASE;
    end

    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        cp_next     = cp_reg;
        left_next   = left_reg;
        failed_next = failed_reg;
        seen_next   = seen_reg;
        do_emit     = 1'b0;
        cp_emit     = cp_reg;
        emit        = '0;

        if (end_of_string) begin
            emit.count     = 2'd1;
            emit.r0.status = (failed_reg || phase_reg != PH_IDLE || left_reg != 2'd0 ||
                              !seen_reg) ? ST_ERR : ST_OK;
            emit.r0.last   = 1'b1;
            phase_next     = PH_IDLE;
            nibble_next    = '0;
            cp_next        = '0;
            left_next      = '0;
            failed_next    = 1'b0;
            seen_next      = 1'b0;
        end else begin
            seen_next = 1'b1;
            if (!failed_reg) begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (unit == PERCENT_CHAR) begin
                            phase_next = PH_HI;
                        end else if (left_reg != 2'd0) begin
                            failed_next = 1'b1;
                        end else begin
                            emit.count   = 2'd1;
                            emit.r0.unit = unit;
                            emit.r0.last = 1'b1;
                        end
                    end
                    PH_HI: begin
                        if (hv[4]) begin
                            failed_next = 1'b1;
                            phase_next  = PH_IDLE;
                        end else begin
                            nibble_next = hv[3:0];
                            phase_next  = PH_LO;
                        end
                    end
                    PH_LO: begin
                        phase_next = PH_IDLE;
                        if (hv[4]) begin
                            failed_next = 1'b1;
                        end else if (left_reg != 2'd0) begin
                            // Continuation byte expected.
                            if (byte_val[7:6] != 2'b10) begin
                                failed_next = 1'b1;
                            end else begin
                                cp_next   = cp_cont;
                                left_next = left_dec;
                                cp_emit   = cp_cont;
                                if (left_dec == 2'd0) begin
                                    if (cp_cont[CP_W-1:11] == 10'h01B || cp_cont > CP_MAX) begin
                                        failed_next = 1'b1;
                                    end else begin
                                        do_emit = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            // Lead byte.
                            priority if (byte_val[7] == 1'b0) begin
                                cp_emit = {13'd0, byte_val};
                                do_emit = 1'b1;
                            end else if (byte_val[7:6] == 2'b10) begin
                                failed_next = 1'b1;
                            end else if (byte_val[7:5] == 3'b110) begin
                                cp_next   = {16'd0, byte_val[4:0]};
                                left_next = 2'd1;
                            end else if (byte_val[7:4] == 4'b1110) begin
                                cp_next   = {17'd0, byte_val[3:0]};
                                left_next = 2'd2;
                            end else if (byte_val[7:3] == 5'b11110) begin
                                cp_next   = {18'd0, byte_val[2:0]};
                                left_next = 2'd3;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            if (do_emit) begin
                if (cp_emit >= SUPP_BASE) begin
                    emit.count   = 2'd2;
                    emit.r0.unit = HI_SURR_BASE + {6'd0, cp_off[19:10]};
                    emit.r1.unit = LO_SURR_BASE | {6'd0, cp_emit[9:0]};
                    emit.r1.last = 1'b1;
                end else begin
                    emit.count   = 2'd1;
                    emit.r0.unit = cp_emit[UNIT_W-1:0];
                    emit.r0.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            nibble_reg <= '0;
            cp_reg     <= '0;
            left_reg   <= '0;
            failed_reg <= 1'b0;
            seen_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            cp_reg     <= cp_next;
            left_reg   <= left_next;
            failed_reg <= failed_next;
            seen_reg   <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_eos_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_string |-> emit.count == 2'd1 && emit.r0.last && emit.r0.status != ST_UNIT)
        else $error("end of string must give exactly one status result");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && end_of_string |=> phase_reg == PH_IDLE && !failed_reg && left_reg == 2'd0 &&
        !seen_reg)
        else $error("decoder state not cleared after end of string");

    a_pair_is_surrogates: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.count == 2'd2 |-> emit.r0.unit[15:10] == 6'b110110 &&
        emit.r1.unit[15:10] == 6'b110111 && !emit.r0.last && emit.r1.last)
        else $error("two-result transaction is not a surrogate pair");
`endif

endmodule

/* design/pud_out_buf.sv */
// ----------------------------------------------------------------------------
// pud_out_buf
// Two-entry result buffer that holds the results of one input transaction
// and presents them in order on the result channel.
// ----------------------------------------------------------------------------
module pud_out_buf
    import pud_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  emit_t   emit,
    output logic    can_load,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t head
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head     = slot0_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load) begin
            cnt_next   = emit.count;
            slot0_next = emit.r0;
            slot1_next = emit.r1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_load_only_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready))
        else $error("result buffer loaded while holding undelivered results");

    a_pair_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && m_ready |=> cnt_reg == 2'd1 && slot0_reg == $past(slot1_reg))
        else $error("second result of a pair lost");
`endif

endmodule

/* design/percent_utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// percent_utf8_to_utf16_decoder
// Decodes a UTF-16 path string with percent escapes holding UTF-8 bytes into
// plain UTF-16, with an ok or error status at the end of each string.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_unit[15:0], s_end_of_string
//  m_        out        m_valid/m_ready    m_unit_out[15:0], m_status[1:0], m_run_last
//
// One input transaction is taken every cycle while s_ready is high. Each
// transaction gives zero, one or two result transactions; the second result
// of a surrogate pair is held in the result buffer, and a new input waits
// in the input register until the buffer can take its results.
// A result passes through the input register and then the result buffer
// before it reaches the result channel.
// aresetn is synchronous and active low; it clears the decoder state and
// empties both the input register and the result buffer.
// A stall on m_ready holds the pending results; the input register accepts
// one more transaction and then s_ready drops until the buffer drains.
// ----------------------------------------------------------------------------
module percent_utf8_to_utf16_decoder
    import pud_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [UNIT_W-1:0]   s_unit,
    input  logic                s_end_of_string,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [UNIT_W-1:0]   m_unit_out,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_run_last
);

    // Input register: holds one accepted transaction until the decoder can
    // place its results in the result buffer.
    logic              in_valid_reg;
    logic [UNIT_W-1:0] in_unit_reg;
    logic              in_eos_reg;

    logic    can_load;
    logic    fire;
    emit_t   emit;
    result_t head;

    // The decoder consumes the registered transaction only when the result
    // buffer will be free in this cycle, so its state and the buffered
    // results always advance together.
    assign fire    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_unit_reg <= s_unit;
            in_eos_reg  <= s_end_of_string;
        end
    end

    // Escape parsing, UTF-8 assembly and UTF-16 encoding in one pass.
    pud_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .unit          (in_unit_reg),
        .end_of_string (in_eos_reg),
        .emit          (emit)
    );

    // Result buffer: up to two results per transaction, delivered in order.
    pud_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .emit     (emit),
        .can_load (can_load),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .head     (head)
    );

    assign m_unit_out = head.unit;
    assign m_status   = head.status;
    assign m_run_last = head.last;

endmodule
